// ===== sv/q2e_pkg.sv =====
`default_nettype none
package q2e_pkg;

    // Fixed-point constants (radians Q30, centidegrees per radian Q16)
    localparam logic signed [33:0] PI_Q30       = 34'sd3373259426;
    localparam logic        [28:0] CDEG_PER_RAD = 29'd375493621;
    localparam int                 NORM_STAGES  = 6;
    localparam int                 CDEG_STAGES  = 3;
    localparam int                 SQRT_CELLS   = 29;

    // Vector state of one arctangent in flight
    typedef struct packed {
        logic signed [43:0] x;
        logic signed [43:0] y;
        logic signed [33:0] z;
        logic               zero;
    } t_cv;

    // State of one square root in flight, with the pitch sine carried along
    typedef struct packed {
        logic        [56:0] v;
        logic        [57:0] res;
        logic signed [29:0] s;
    } t_sq;

    // atan(2^-i) in radians Q30, rounded to nearest
    function automatic logic signed [33:0] atan_q30(input int i);
        logic signed [33:0] a;
        case (i)
            0:       a = 34'sd843314857;
            1:       a = 34'sd497837829;
            2:       a = 34'sd263043837;
            3:       a = 34'sd133525159;
            4:       a = 34'sd67021688;
            5:       a = 34'sd33543516;
            6:       a = 34'sd16775851;
            7:       a = 34'sd8388437;
            8:       a = 34'sd4194283;
            9:       a = 34'sd2097149;
            default: a = 34'sd1 <<< (30 - i);
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// ===== sv/quaternion_to_euler_angles.sv =====
`default_nettype none
// Quaternion to ZYX Euler angles.
// Slave stream: one quaternion item per transfer, tdata = {z, y, x, w},
// each signed Q2.14. Master stream: one angle item per quaternion, tdata =
// {pad, roll, pitch, yaw} in signed centidegrees.
// The block is a fully pipelined chain: products, sums, a row of 29 square
// root cells for the pitch cosine, a six-step normalizer, a row of
// CORDIC_STEPS rotation cells for each of the three angles and a three-step
// scale to centidegrees. A new item is taken every cycle unless the output
// stalls the chain.
// The whole chain advances together: while a result waits on the output and
// the receiver holds tready low, every stage holds and tready on the slave
// side drops; as soon as the output is taken or empty, the chain moves.
// Reset (synchronous, active low) empties the chain; data in flight is lost.
module quaternion_to_euler_angles #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [63:0] i_s_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [47:0] o_m_tdata    // yaw, pitch, roll, zero pad
);
    import q2e_pkg::*;

    localparam int DLY  = SQRT_CELLS + 2;
    localparam int ALAT = 1 + NORM_STAGES + CORDIC_STEPS + CDEG_STAGES;
    localparam int LAT  = 2 + DLY + ALAT;

    logic           en;
    logic [LAT-1:0] r_vld;

    assign en         = !r_vld[LAT-1] || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_vld[LAT-1];

    // Track which stages hold an item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_tvalid};
        end
    end

    // Products of the quaternion parts
    logic signed [31:0] r_wz, r_xy, r_yy, r_zz, r_wy, r_zx, r_wx, r_yz, r_xx;
    logic signed [15:0] qw, qx, qy, qz;

    assign qw = i_s_tdata[15:0];
    assign qx = i_s_tdata[31:16];
    assign qy = i_s_tdata[47:32];
    assign qz = i_s_tdata[63:48];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wz <= qw * qz;
            r_xy <= qx * qy;
            r_yy <= qy * qy;
            r_zz <= qz * qz;
            r_wy <= qw * qy;
            r_zx <= qz * qx;
            r_wx <= qw * qx;
            r_yz <= qy * qz;
            r_xx <= qx * qx;
        end
    end

    // Numerators, denominators and the clamped pitch sine
    logic signed [33:0] r_yn, r_yd, r_rn, r_rd;
    logic signed [29:0] r_s;
    logic signed [33:0] s_raw;

    assign s_raw = (34'(r_wy) - 34'(r_zx)) <<< 1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_yn <= (34'(r_wz) + 34'(r_xy)) <<< 1;
            r_yd <= (34'sd1 <<< 28) - ((34'(r_yy) + 34'(r_zz)) <<< 1);
            r_rn <= (34'(r_wx) + 34'(r_yz)) <<< 1;
            r_rd <= (34'sd1 <<< 28) - ((34'(r_xx) + 34'(r_yy)) <<< 1);
            if (s_raw > (34'sd1 <<< 28)) begin
                r_s <= 30'sd1 <<< 28;
            end else if (s_raw < -(34'sd1 <<< 28)) begin
                r_s <= -(30'sd1 <<< 28);
            end else begin
                r_s <= 30'(s_raw);
            end
        end
    end

    // Square of the sine, then the remainder for the cosine root
    logic        [56:0] r_sq;
    logic signed [29:0] r_s2;
    t_sq                sq [0:SQRT_CELLS];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq     <= 57'(r_s * r_s);
            r_s2     <= r_s;
            sq[0].v   <= (57'd1 << 56) - r_sq;
            sq[0].res <= '0;
            sq[0].s   <= r_s2;
        end
    end

    for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
        q2e_sqrt_cell #(.BIT_POS(56 - 2 * k)) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (sq[k]),
            .o_d   (sq[k+1])
        );
    end

    // Delay yaw and roll terms alongside the root
    logic signed [33:0] r_dyn [0:DLY-1];
    logic signed [33:0] r_dyd [0:DLY-1];
    logic signed [33:0] r_drn [0:DLY-1];
    logic signed [33:0] r_drd [0:DLY-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dyn[0] <= r_yn;
            r_dyd[0] <= r_yd;
            r_drn[0] <= r_rn;
            r_drd[0] <= r_rd;
            for (int k = 1; k < DLY; k++) begin
                r_dyn[k] <= r_dyn[k-1];
                r_dyd[k] <= r_dyd[k-1];
                r_drn[k] <= r_drn[k-1];
                r_drd[k] <= r_drd[k-1];
            end
        end
    end

    // Three arctangent pipelines
    logic signed [15:0] yaw, pitch, roll;
    logic signed [33:0] p_y, p_x;

    assign p_y = 34'(sq[SQRT_CELLS].s);
    assign p_x = {5'd0, sq[SQRT_CELLS].res[28:0]};

    q2e_atan2 #(.CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
        .i_clk (i_clk), .i_en (en),
        .i_y (r_dyn[DLY-1]), .i_x (r_dyd[DLY-1]), .o_angle (yaw)
    );

    q2e_atan2 #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
        .i_clk (i_clk), .i_en (en),
        .i_y (p_y), .i_x (p_x), .o_angle (pitch)
    );

    q2e_atan2 #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (
        .i_clk (i_clk), .i_en (en),
        .i_y (r_drn[DLY-1]), .i_x (r_drd[DLY-1]), .o_angle (roll)
    );

    assign o_m_tdata = {1'b0, roll, pitch[14:0], yaw};

    // Stalled chain keeps its occupancy
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline occupancy changed during stall");

    // Accepted item enters the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_vld[0])
        else $error("accepted item not tracked");

    // Idle input leaves a bubble
    a_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_s_tvalid && o_s_tready) |=> !r_vld[0])
        else $error("bubble tracked as item");

endmodule
`default_nettype wire

// ===== sv/q2e_sqrt_cell.sv =====
`default_nettype none
module q2e_sqrt_cell #(
    parameter int BIT_POS = 56
) (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire q2e_pkg::t_sq i_d,
    output q2e_pkg::t_sq      o_d
);
    import q2e_pkg::*;

    localparam logic [57:0] BIT = 58'd1 << BIT_POS;

    logic [57:0] trial;
    t_sq         n_d;

    // Try one result bit: subtract when the remainder allows it
    always_comb begin
        trial = i_d.res + BIT;
        n_d   = i_d;
        if ({1'b0, i_d.v} >= trial) begin
            n_d.v   = i_d.v - trial[56:0];
            n_d.res = (i_d.res >> 1) + BIT;
        end else begin
            n_d.res = i_d.res >> 1;
        end
    end

    // Hand the state to the next cell
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_d <= n_d;
        end
    end

endmodule
`default_nettype wire

// ===== sv/q2e_cordic_cell.sv =====
`default_nettype none
module q2e_cordic_cell #(
    parameter int STEP = 0
) (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire q2e_pkg::t_cv i_d,
    output q2e_pkg::t_cv      o_d
);
    import q2e_pkg::*;

    localparam logic signed [33:0] ANGLE = atan_q30(STEP);

    logic signed [43:0] dx;
    logic signed [43:0] dy;
    t_cv                n_d;

    // Rotate toward the x axis by one micro-angle
    always_comb begin
        dx  = i_d.y >>> STEP;
        dy  = i_d.x >>> STEP;
        n_d = i_d;
        if (!i_d.y[43]) begin
            n_d.x = i_d.x + dx;
            n_d.y = i_d.y - dy;
            n_d.z = i_d.z + ANGLE;
        end else begin
            n_d.x = i_d.x - dx;
            n_d.y = i_d.y + dy;
            n_d.z = i_d.z - ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_d <= n_d;
        end
    end

endmodule
`default_nettype wire

// ===== sv/q2e_atan2.sv =====
`default_nettype none
module q2e_atan2 #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [33:0] i_y,
    input  wire logic signed [33:0] i_x,
    output logic signed      [15:0] o_angle
);
    import q2e_pkg::*;

    logic signed [43:0] xe;
    logic signed [43:0] ye;
    logic        [43:0] ax;
    logic        [43:0] ay;
    t_cv                n_pre;
    logic        [40:0] n_m;

    t_cv                nrm [0:NORM_STAGES];
    logic        [40:0] mag [0:NORM_STAGES];
    t_cv                chain [0:CORDIC_STEPS];

    // Fold the left half-plane onto the right one and find the magnitude
    always_comb begin
        xe         = 44'(i_x);
        ye         = 44'(i_y);
        n_pre.zero = (i_x == '0) && (i_y == '0);
        n_pre.z    = '0;
        if (i_x[33]) begin
            n_pre.z = i_y[33] ? -PI_Q30 : PI_Q30;
            xe      = -xe;
            ye      = -ye;
        end
        n_pre.x = xe;
        n_pre.y = ye;
        ax      = xe[43] ? 44'(-xe) : 44'(xe);
        ay      = ye[43] ? 44'(-ye) : 44'(ye);
        n_m     = (ax > ay) ? ax[40:0] : ay[40:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            nrm[0] <= n_pre;
            mag[0] <= n_m;
        end
    end

    // Normalize so the larger magnitude lands in [2^40, 2^41)
    for (genvar k = 0; k < NORM_STAGES; k++) begin : g_norm
        localparam int SH = 32 >> k;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if ((mag[k] >> (41 - SH)) == '0) begin
                    nrm[k+1].x    <= nrm[k].x <<< SH;
                    nrm[k+1].y    <= nrm[k].y <<< SH;
                    nrm[k+1].z    <= nrm[k].z;
                    nrm[k+1].zero <= nrm[k].zero;
                    mag[k+1]      <= mag[k] << SH;
                end else begin
                    nrm[k+1] <= nrm[k];
                    mag[k+1] <= mag[k];
                end
            end
        end
    end

    assign chain[0] = nrm[NORM_STAGES];

    // Row of rotation cells
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
        q2e_cordic_cell #(.STEP(k)) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_d   (chain[k]),
            .o_d   (chain[k+1])
        );
    end

    // Scale radians to centidegrees in three steps
    logic        [33:0] r_abs;
    logic               r_neg_a;
    logic        [45:0] r_plo;
    logic        [45:0] r_phi;
    logic               r_neg_b;
    logic        [63:0] scaled;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg_a <= chain[CORDIC_STEPS].z[33] && !chain[CORDIC_STEPS].zero;
            if (chain[CORDIC_STEPS].zero) begin
                r_abs <= '0;
            end else if (chain[CORDIC_STEPS].z[33]) begin
                r_abs <= 34'(-chain[CORDIC_STEPS].z);
            end else begin
                r_abs <= 34'(chain[CORDIC_STEPS].z);
            end
            r_plo   <= 46'({29'd0, r_abs[16:0]} * {17'd0, CDEG_PER_RAD});
            r_phi   <= 46'({29'd0, r_abs[33:17]} * {17'd0, CDEG_PER_RAD});
            r_neg_b <= r_neg_a;
            o_angle <= r_neg_b ? -$signed(scaled[61:46]) : $signed(scaled[61:46]);
        end
    end

    assign scaled = ({18'd0, r_phi} << 17) + {18'd0, r_plo} + (64'd1 << 45);

endmodule
`default_nettype wire
